// ===== rtl/bsrs_pkg.sv =====
// Shared types and constants for the bright spot row steering core.
// No dependencies; every other file refers to this package by scoped names.
package bsrs_pkg;

	localparam int SAMPLE_W  = 8;
	localparam int THRESH_W  = 8;
	localparam int STRIDE_W  = 14;
	localparam int COUNT_W   = 12;
	localparam int GAIN_W    = 16;
	localparam int HIT_W     = 14;
	localparam int HALF_W    = STRIDE_W - 1;
	localparam int RATE_W    = 17;
	localparam int PROD_W    = GAIN_W + HIT_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// columns tested are those with col mod 3 == 0
	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

	localparam logic [GAIN_W-1:0] RATE_MAX_MAG = 16'hFFFF;

	// cycles from the first busy cycle of the rate unit to its done cycle
	localparam int RATE_FIN_DELAY = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd3;

	localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd240;
	localparam logic [STRIDE_W-1:0] STRIDE_RST    = 14'd2400;
	localparam logic [COUNT_W-1:0]  ROWS_RST      = 12'd800;
	localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'd3277;

	typedef enum logic [1:0] {
		RATE_IDLE,
		RATE_MUL,
		RATE_DIV,
		RATE_FIN
	} rate_state_t;

	typedef struct packed {
		logic              report;
		logic              stop;
		logic [HIT_W-1:0]  first;
		logic [HIT_W-1:0]  last;
	} scan_ev_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [HIT_W-1:0]  mag;
		logic              neg;
		logic [HALF_W-1:0] half;
	} rate_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [RATE_W-1:0] rate;
	} rate_res_t;

endpackage

// ===== rtl/bsrs_sample_if.sv =====
// Input byte channel: valid/ready handshake carrying one image byte.
// Depends on bsrs_pkg for the field width.
interface bsrs_sample_if;
	logic                          valid;
	logic                          ready;
	logic [bsrs_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/bsrs_result_if.sv =====
// Result channel: valid/ready handshake carrying steering rate and found flag.
// Depends on bsrs_pkg for the field width.
interface bsrs_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [bsrs_pkg::RATE_W-1:0] steer_rate;
	logic                               found;

	modport source (output valid, output steer_rate, output found, input ready);
	modport sink   (input valid, input steer_rate, input found, output ready);
endinterface

// ===== rtl/bsrs_scan.sv =====
// Row/column scanner: counters, threshold test and first/last hit tracking.
// Depends on bsrs_pkg; reports row-end and frame-end events to the top level.
module bsrs_scan #(
	parameter int COLUMN_BITS = 14,
	parameter int ROW_BITS    = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [bsrs_pkg::SAMPLE_W-1:0]   sample,
	input  logic [bsrs_pkg::THRESH_W-1:0]   threshold,
	input  logic [bsrs_pkg::STRIDE_W-1:0]   stride,
	input  logic [bsrs_pkg::COUNT_W-1:0]    rows,
	output bsrs_pkg::scan_ev_t              ev
);

	localparam int CMP_C = (COLUMN_BITS > bsrs_pkg::STRIDE_W ?
		COLUMN_BITS : bsrs_pkg::STRIDE_W) + 1;
	localparam int CMP_R = (ROW_BITS > bsrs_pkg::COUNT_W ?
		ROW_BITS : bsrs_pkg::COUNT_W) + 1;

	logic [COLUMN_BITS-1:0]          col_q;
	logic [ROW_BITS-1:0]             row_q;
	logic [bsrs_pkg::PHASE_W-1:0]    phase_q;
	logic [bsrs_pkg::HIT_W-1:0]      first_q;
	logic [bsrs_pkg::HIT_W-1:0]      last_q;
	logic                            has_hit_q;
	logic                            reported_q;

	logic                            row_end;
	logic                            frame_end;
	logic                            hit;
	logic                            has_n;
	logic [bsrs_pkg::HIT_W-1:0]      col_hit;
	logic [bsrs_pkg::HIT_W-1:0]      first_n;
	logic [bsrs_pkg::HIT_W-1:0]      last_n;

	always_comb begin
		row_end   = ((CMP_C'(col_q) + CMP_C'(1)) >= CMP_C'(stride)) || (col_q == '1);
		frame_end = row_end &&
			(((CMP_R'(row_q) + CMP_R'(1)) >= CMP_R'(rows)) || (row_q == '1));
		hit       = !reported_q && (phase_q == '0) && (sample > threshold);
		col_hit   = bsrs_pkg::HIT_W'(col_q);
		first_n   = (hit && !has_hit_q) ? col_hit : first_q;
		last_n    = hit ? col_hit : last_q;
		has_n     = has_hit_q || hit;
		ev.report = row_end && !reported_q && has_n;
		ev.stop   = frame_end && !reported_q && !ev.report;
		ev.first  = first_n;
		ev.last   = last_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			phase_q    <= '0;
			first_q    <= '0;
			last_q     <= '0;
			has_hit_q  <= 1'b0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				col_q     <= '0;
				phase_q   <= '0;
				has_hit_q <= 1'b0;
				if (frame_end) begin
					row_q      <= '0;
					reported_q <= 1'b0;
					first_q    <= '0;
					last_q     <= '0;
				end else begin
					row_q      <= row_q + ROW_BITS'(1);
					reported_q <= reported_q || ev.report;
					first_q    <= first_n;
					last_q     <= last_n;
				end
			end else begin
				col_q     <= col_q + COLUMN_BITS'(1);
				phase_q   <= (phase_q == bsrs_pkg::PHASE_LAST) ? '0 :
					phase_q + bsrs_pkg::PHASE_W'(1);
				has_hit_q <= has_n;
				first_q   <= first_n;
				last_q    <= last_n;
			end
		end
	end

endmodule

// ===== rtl/bsrs_rate_unit.sv =====
// Iterative rate unit: one multiply, then restoring division one bit a cycle,
// then saturation and sign. Depends on bsrs_pkg for request/result types.
module bsrs_rate_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bsrs_pkg::rate_req_t  req,
	output logic                 busy,
	output bsrs_pkg::rate_res_t  res
);

	localparam int CNT_W = $clog2(bsrs_pkg::PROD_W);

	bsrs_pkg::rate_state_t state_q;
	bsrs_pkg::rate_state_t state_n;

	bsrs_pkg::rate_req_t             req_q;
	logic [bsrs_pkg::PROD_W-1:0]     dvd_q;
	logic [bsrs_pkg::HALF_W-1:0]     rem_q;
	logic [CNT_W-1:0]                cnt_q;

	logic [bsrs_pkg::HALF_W:0]       shifted;
	logic                            ge;
	logic [bsrs_pkg::GAIN_W-1:0]     sat;
	logic [bsrs_pkg::RATE_W-1:0]     mag_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bsrs_pkg::RATE_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			bsrs_pkg::RATE_IDLE: if (start) state_n = bsrs_pkg::RATE_MUL;
			bsrs_pkg::RATE_MUL:  state_n = bsrs_pkg::RATE_DIV;
			bsrs_pkg::RATE_DIV:  if (cnt_q == '0) state_n = bsrs_pkg::RATE_FIN;
			bsrs_pkg::RATE_FIN:  state_n = bsrs_pkg::RATE_IDLE;
			default:             state_n = bsrs_pkg::RATE_IDLE;
		endcase
		busy = (state_q != bsrs_pkg::RATE_IDLE);
	end

	// one quotient bit per cycle; remainder stays below the divisor
	always_comb begin
		shifted = {rem_q, dvd_q[bsrs_pkg::PROD_W-1]};
		ge      = (shifted >= {1'b0, req_q.half});
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bsrs_pkg::RATE_IDLE: begin
				if (start)
					req_q <= req;
			end
			bsrs_pkg::RATE_MUL: begin
				dvd_q <= bsrs_pkg::PROD_W'(req_q.gain) * bsrs_pkg::PROD_W'(req_q.mag);
				rem_q <= '0;
				cnt_q <= CNT_W'(bsrs_pkg::PROD_W - 1);
			end
			bsrs_pkg::RATE_DIV: begin
				rem_q <= ge ? bsrs_pkg::HALF_W'(shifted - {1'b0, req_q.half}) :
					bsrs_pkg::HALF_W'(shifted);
				dvd_q <= {dvd_q[bsrs_pkg::PROD_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sat      = (dvd_q > bsrs_pkg::PROD_W'(bsrs_pkg::RATE_MAX_MAG)) ?
			bsrs_pkg::RATE_MAX_MAG : dvd_q[bsrs_pkg::GAIN_W-1:0];
		mag_ext  = {1'b0, sat};
		res.done = (state_q == bsrs_pkg::RATE_FIN);
		res.rate = req_q.neg ? -$signed(mag_ext) : $signed(mag_ext);
	end

endmodule

// ===== rtl/bright_spot_row_steering_core.sv =====
// Top level of the bright spot row steering core: configuration registers,
// output register and glue. Depends on bsrs_pkg, the two channel interfaces,
// bsrs_scan and bsrs_rate_unit.
//
// channel    role   payload                     handshake
// pixels     sink   sample[7:0]                 valid/ready
// steering   source steer_rate[16:0], found     valid/ready
// cfg        write  cfg_index[1:0], cfg_data    cfg_we, no wait
//
// One byte per cycle while scanning and not stalled. The byte that ends the
// reporting row starts the rate unit, and ready stays low while it runs its
// multiply step, the restoring division and the finish step.
// Stop results and zero-width rows go straight to the output register.
// A result held by the sink stalls input until that transaction is taken.
// Reset clears counters, flags and control state; no clearing pass.
module bright_spot_row_steering_core #(
	parameter int COLUMN_BITS = 14,
	parameter int ROW_BITS    = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bsrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	bsrs_sample_if.sink                       pixels,
	bsrs_result_if.source                     steering
);

	logic [bsrs_pkg::THRESH_W-1:0] threshold_q;
	logic [bsrs_pkg::STRIDE_W-1:0] stride_q;
	logic [bsrs_pkg::COUNT_W-1:0]  rows_q;
	logic [bsrs_pkg::GAIN_W-1:0]   gain_q;

	logic                              out_valid_q;
	logic signed [bsrs_pkg::RATE_W-1:0] rate_q;
	logic                              found_q;

	logic                          busy;
	logic                          accept;
	logic                          start;
	bsrs_pkg::scan_ev_t            ev;
	bsrs_pkg::rate_req_t           req;
	bsrs_pkg::rate_res_t           rate_res;

	logic [bsrs_pkg::HALF_W-1:0]   half;
	logic [bsrs_pkg::HIT_W:0]      hit_sum;
	logic [bsrs_pkg::HIT_W:0]      diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bsrs_pkg::THRESHOLD_RST;
			stride_q    <= bsrs_pkg::STRIDE_RST;
			rows_q      <= bsrs_pkg::ROWS_RST;
			gain_q      <= bsrs_pkg::GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bsrs_pkg::CFG_THRESHOLD: threshold_q <= bsrs_pkg::THRESH_W'(cfg_data);
				bsrs_pkg::CFG_STRIDE:    stride_q    <= bsrs_pkg::STRIDE_W'(cfg_data);
				bsrs_pkg::CFG_ROWS:      rows_q      <= bsrs_pkg::COUNT_W'(cfg_data);
				bsrs_pkg::CFG_GAIN:      gain_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pixels.ready = !busy && (!out_valid_q || steering.ready);
	assign accept       = pixels.valid && pixels.ready;

	bsrs_scan #(
		.COLUMN_BITS (COLUMN_BITS),
		.ROW_BITS    (ROW_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (pixels.sample),
		.threshold (threshold_q),
		.stride    (stride_q),
		.rows      (rows_q),
		.ev        (ev)
	);

	// diff = half - center, center = floor((first + last) / 2)
	always_comb begin
		half     = stride_q[bsrs_pkg::STRIDE_W-1:1];
		hit_sum  = {1'b0, ev.first} + {1'b0, ev.last};
		diff     = {2'b00, half} - {1'b0, hit_sum[bsrs_pkg::HIT_W:1]};
		req.gain = gain_q;
		req.neg  = diff[bsrs_pkg::HIT_W];
		req.mag  = req.neg ? bsrs_pkg::HIT_W'(-diff) : bsrs_pkg::HIT_W'(diff);
		req.half = half;
		start    = accept && ev.report && (half != '0);
	end

	bsrs_rate_unit u_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.res    (rate_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rate_res.done || (accept && (ev.stop || (ev.report && half == '0)))) begin
			out_valid_q <= 1'b1;
		end else if (steering.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rate_res.done) begin
			rate_q  <= rate_res.rate;
			found_q <= 1'b1;
		end else if (accept && ev.report && half == '0) begin
			rate_q  <= '0;
			found_q <= 1'b1;
		end else if (accept && ev.stop) begin
			rate_q  <= '0;
			found_q <= 1'b0;
		end
	end

	assign steering.valid      = out_valid_q;
	assign steering.steer_rate = rate_q;
	assign steering.found      = found_q;

	a_rate_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ##(bsrs_pkg::RATE_FIN_DELAY) rate_res.done)
		else $error("rate unit did not finish on schedule");

	a_out_free_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		rate_res.done |-> !out_valid_q)
		else $error("rate result would overwrite a pending transaction");

	a_stop_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(steering.valid && !steering.found) |-> (steering.steer_rate == '0))
		else $error("stop transaction carries a nonzero rate");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept)
		else $error("byte accepted while rate unit busy");

endmodule

// ===== test/bsrs_steer_checker.sv =====
// Checker for the bright spot row steering core: watches the config port and both channels.
// It predicts the steering result of every frame and compares it with what the core sends.
// Depends on bsrs_pkg, bsrs_sample_if and bsrs_result_if.
module bsrs_steer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsrs_pkg::CFG_DATA_W-1:0] cfg_data,
	bsrs_sample_if                          pixels,
	bsrs_result_if                          steering,
	output int                              mismatches,
	output int                              outstanding
);

	typedef struct packed {
		logic signed [bsrs_pkg::RATE_W-1:0] rate;
		logic                               found;
	} steer_t;

	steer_t pending_steer[$];

	logic [bsrs_pkg::THRESH_W-1:0] thr_q;
	logic [bsrs_pkg::STRIDE_W-1:0] stride_q;
	logic [bsrs_pkg::COUNT_W-1:0]  rows_q;
	logic [bsrs_pkg::GAIN_W-1:0]   gain_q;

	logic [bsrs_pkg::STRIDE_W-1:0] col_pos;
	logic [bsrs_pkg::COUNT_W-1:0]  row_pos;
	logic [bsrs_pkg::HIT_W-1:0]    span_lo;
	logic [bsrs_pkg::HIT_W-1:0]    span_hi;
	bit                            spot_in_row;
	bit                            frame_done;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic logic signed [bsrs_pkg::RATE_W-1:0] steer_from_span();
		longint half, mid, q;
		half = longint'(stride_q) >> 1;
		mid = (longint'(span_lo) + longint'(span_hi)) >> 1;
		if (half == 0)
			return '0;
		q = longint'(gain_q) * (half - mid) / half;
		if (q > longint'(bsrs_pkg::RATE_MAX_MAG))
			q = longint'(bsrs_pkg::RATE_MAX_MAG);
		else if (q < -longint'(bsrs_pkg::RATE_MAX_MAG))
			q = -longint'(bsrs_pkg::RATE_MAX_MAG);
		return q[bsrs_pkg::RATE_W-1:0];
	endfunction

	// one byte of the frame; emit is set when it closes out a steering decision
	function automatic void scan_byte(input logic [bsrs_pkg::SAMPLE_W-1:0] s,
			output bit emit, output steer_t res);
		bit row_end, frame_end;
		row_end = (int'(col_pos) + 1 >= int'(stride_q)) || (col_pos == '1);
		frame_end = row_end && ((int'(row_pos) + 1 >= int'(rows_q)) || (row_pos == '1));
		emit = 1'b0;
		res = '0;
		if (!frame_done && (col_pos % 3 == 0) && s > thr_q) begin
			if (!spot_in_row)
				span_lo = col_pos;
			span_hi = col_pos;
			spot_in_row = 1'b1;
		end
		if (row_end) begin
			if (!frame_done && spot_in_row) begin
				res.rate = steer_from_span();
				res.found = 1'b1;
				emit = 1'b1;
				frame_done = 1'b1;
			end
			spot_in_row = 1'b0;
			col_pos = '0;
			if (frame_end) begin
				// no spot anywhere in the frame: stop
				if (!frame_done) begin
					res = '0;
					emit = 1'b1;
				end
				frame_done = 1'b0;
				row_pos = '0;
				span_lo = '0;
				span_hi = '0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		steer_t got, want;
		bit emit;
		if (!arst_n) begin
			thr_q = bsrs_pkg::THRESHOLD_RST;
			stride_q = bsrs_pkg::STRIDE_RST;
			rows_q = bsrs_pkg::ROWS_RST;
			gain_q = bsrs_pkg::GAIN_RST;
			col_pos = '0;
			row_pos = '0;
			span_lo = '0;
			span_hi = '0;
			spot_in_row = 1'b0;
			frame_done = 1'b0;
			pending_steer.delete();
			outstanding = 0;
		end else begin
			if (steering.valid && steering.ready) begin
				got.rate = steering.steer_rate;
				got.found = steering.found;
				if (pending_steer.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected steering transaction: rate %0d found %0b",
							$realtime, got.rate, got.found);
					mismatches++;
				end else begin
					want = pending_steer.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"%0t: steering mismatch: expected rate %0d found %0b,",
								" got rate %0d found %0b"},
								$realtime, want.rate, want.found, got.rate, got.found);
						mismatches++;
					end
				end
			end
			// a byte taken at this edge still sees the old register values
			if (pixels.valid && pixels.ready) begin
				scan_byte(pixels.sample, emit, want);
				if (emit)
					pending_steer.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					bsrs_pkg::CFG_THRESHOLD: thr_q = cfg_data[bsrs_pkg::THRESH_W-1:0];
					bsrs_pkg::CFG_STRIDE:    stride_q = cfg_data[bsrs_pkg::STRIDE_W-1:0];
					bsrs_pkg::CFG_ROWS:      rows_q = cfg_data[bsrs_pkg::COUNT_W-1:0];
					bsrs_pkg::CFG_GAIN:      gain_q = cfg_data[bsrs_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			outstanding = pending_steer.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// Top of the bright spot row steering testbench: clock, reset, byte stream, config writes
// and result back-pressure; checking is done by bsrs_steer_checker.
// Depends on bsrs_pkg, both channel interfaces, the core and the checker.
module testbench;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bsrs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bsrs_pkg::CFG_DATA_W-1:0] cfg_data;

	bsrs_sample_if pixels_if();
	bsrs_result_if steering_if();

	int chk_mismatches;
	int chk_outstanding;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;

	// current register values, used to shape frames
	int cur_thr, cur_stride, cur_rows;
	int scanned_bytes;

	bright_spot_row_steering_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels_if),
		.steering (steering_if)
	);

	bsrs_steer_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixels     (pixels_if),
		.steering   (steering_if),
		.mismatches (chk_mismatches),
		.outstanding(chk_outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls, or one long hold-off when requested
	initial begin
		steering_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				steering_if.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
				steering_if.ready <= 1'b1;
			end else begin
				steering_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic push_sample(input logic [bsrs_pkg::SAMPLE_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pixels_if.valid <= 1'b0;
			@(negedge clk);
		end
		pixels_if.valid <= 1'b1;
		pixels_if.sample <= b;
		do @(posedge clk); while (!pixels_if.ready);
	endtask

	// stop offering bytes and wait until every expected result is back
	task automatic settle();
		int n;
		@(negedge clk);
		pixels_if.valid <= 1'b0;
		n = 0;
		while (chk_outstanding != 0 && n < 5000) begin
			@(negedge clk);
			n++;
		end
		repeat (bsrs_pkg::RATE_FIN_DELAY + 10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bsrs_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[bsrs_pkg::CFG_DATA_W-1:0];
	endtask

	task automatic apply_setting(input int thr, input int stride, input int rows, input int gain);
		settle();
		write_reg(bsrs_pkg::CFG_THRESHOLD, thr);
		write_reg(bsrs_pkg::CFG_STRIDE, stride);
		write_reg(bsrs_pkg::CFG_ROWS, rows);
		write_reg(bsrs_pkg::CFG_GAIN, gain);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_thr = thr;
		cur_stride = stride;
		cur_rows = rows;
	endtask

	function automatic logic [bsrs_pkg::SAMPLE_W-1:0] rand_byte(input int hi);
		return bsrs_pkg::SAMPLE_W'($urandom_range(hi));
	endfunction

	function automatic logic [bsrs_pkg::SAMPLE_W-1:0] dim_byte();
		return rand_byte(cur_thr);
	endfunction

	function automatic logic [bsrs_pkg::SAMPLE_W-1:0] lit_byte();
		if (cur_thr >= 255)
			return 8'hFF;
		return bsrs_pkg::SAMPLE_W'($urandom_range(255, cur_thr + 1));
	endfunction

	// one frame: dark tested columns up to the spot row, a lit span there, anything after; all random if noisy
	task automatic send_frame(input bit noisy);
		int len, nrows, spot_row, lo, hi, r, c;
		logic [bsrs_pkg::SAMPLE_W-1:0] b;
		len = (cur_stride < 1) ? 1 : cur_stride;
		nrows = (cur_rows < 1) ? 1 : cur_rows;
		spot_row = ($urandom_range(4) == 0) ? -1 : int'($urandom_range(nrows - 1));
		lo = 3 * int'($urandom_range((len - 1) / 3));
		hi = lo + 3 * int'($urandom_range((len - 1 - lo) / 3));
		for (r = 0; r < nrows; r++) begin
			for (c = 0; c < len; c++) begin
				if (noisy || c % 3 != 0 || (spot_row >= 0 && r > spot_row))
					b = rand_byte(255);
				else if (r == spot_row &&
						(c == lo || c == hi || (c > lo && c < hi && $urandom_range(1))))
					b = lit_byte();
				else
					b = dim_byte();
				push_sample(b);
				if (noisy || spot_row < 0 || r <= spot_row)
					scanned_bytes++;
			end
		end
	endtask

	initial begin
		int c, mode, k, pick, thr, stride, rows, gain;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bsrs_pkg::CFG_THRESHOLD;
		cfg_data = '0;
		pixels_if.valid = 1'b0;
		pixels_if.sample = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b0;
		cur_thr = bsrs_pkg::THRESHOLD_RST;
		cur_stride = bsrs_pkg::STRIDE_RST;
		cur_rows = bsrs_pkg::ROWS_RST;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset values: equal-to-threshold at col 0, just above it at col 3
		for (c = 0; c < 12; c++) begin
			if (c == 0)
				push_sample(bsrs_pkg::THRESHOLD_RST);
			else if (c == 3)
				push_sample(bsrs_pkg::THRESHOLD_RST + 8'd1);
			else if (c % 3 == 0)
				push_sample(rand_byte(bsrs_pkg::THRESHOLD_RST));
			else
				push_sample(8'hFF);
		end
		// write in mid-frame: counters kept, the next byte ends the row
		apply_setting(bsrs_pkg::THRESHOLD_RST, 3, 1, bsrs_pkg::GAIN_RST);
		repeat (4) push_sample(8'hFF);

		// spot in the last row, threshold edge, untested columns bright
		apply_setting(100, 9, 2, 65535);
		for (c = 0; c < 9; c++)
			push_sample((c % 3 == 0) ? 8'd100 : 8'hFF);
		for (c = 0; c < 9; c++)
			push_sample(c == 0 ? 8'd101 : c == 3 ? 8'd100 : c == 6 ? 8'hFF : 8'h00);
		// nothing can exceed the top threshold: stop
		apply_setting(255, 9, 2, 65535);
		repeat (18) push_sample(8'hFF);
		// half of zero, gain of zero
		apply_setting(0, 1, 3, 0);
		push_sample(8'h00);
		push_sample(8'h05);
		push_sample(8'h05);
		// stride and row count of zero: every byte is a frame
		apply_setting(0, 0, 0, 3277);
		push_sample(8'h00);
		push_sample(8'h07);
		// largest positive rate
		apply_setting(0, 2, 1, 65535);
		push_sample(8'h01);
		push_sample(8'h00);
		// spot at the far right of the row: most negative rate
		apply_setting(0, 7, 1, 65535);
		for (c = 0; c < 7; c++)
			push_sample(c == 6 ? 8'h01 : (c % 3 == 0) ? 8'h00 : rand_byte(255));
		// several rows, spot in the last one
		apply_setting(128, 3, 4, int'($urandom_range(65535)));
		for (c = 0; c < 12; c++)
			push_sample(c == 9 ? 8'd129 : (c % 3 == 0) ? rand_byte(128) : rand_byte(255));

		for (mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 77 : 0;
			recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 13 : 0;
			for (k = 0; k < 3; k++) begin
				pick = int'($urandom_range(9));
				thr = (pick == 0) ? 0 : (pick == 1) ? 255 : int'($urandom_range(255));
				pick = int'($urandom_range(9));
				stride = (pick == 0) ? int'($urandom_range(2)) : int'($urandom_range(24, 3));
				pick = int'($urandom_range(9));
				rows = (pick == 0) ? 0 : int'($urandom_range(3, 1));
				pick = int'($urandom_range(9));
				gain = (pick == 0) ? 0 : (pick == 1) ? 65535 : int'($urandom_range(65535));
				apply_setting(thr, stride, rows, gain);
				scanned_bytes = 0;
				while (scanned_bytes < 24)
					send_frame($urandom_range(6) == 0);
			end
		end

		// long result hold-off with short frames: the core must stall its input
		apply_setting(0, 3, 1, int'($urandom_range(65535)));
		hold_req = 1'b1;
		repeat (20) send_frame(1'b0);

		settle();
		if (chk_mismatches == 0 && chk_outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
